// ----- src/rra_pkg.sv -----
// ----------------------------------------------------------------------------
// Ring region allocator package
// Shared state codes, status codes, request kinds, merge phases and the stack control group.
// ----------------------------------------------------------------------------
package rra_pkg;

	// Sequencer states of the allocator.
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MRD,
		ST_MHEAD,
		ST_MFOL,
		ST_DECIDE,
		ST_ACUT,
		ST_ANEW,
		ST_AWALK,
		ST_FBRD,
		ST_FBCHK,
		ST_FRCHK,
		ST_DONE
	} rra_state_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NO_SPACE   = 2'd1,
		STAT_BAD_HANDLE = 2'd2,
		STAT_TABLE_FULL = 2'd3
	} rra_status_t;

	// Request kinds.
	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} rra_req_t;

	// Which run a merge pass is working on.
	typedef enum logic {
		PH_HEAD   = 1'b0,
		PH_CURSOR = 1'b1
	} rra_phase_t;

	// Control group for a spare-index stack.
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} rra_stack_ctl_t;

endpackage

// ----- src/ring_region_allocator.sv -----
// ----------------------------------------------------------------------------
// Ring region allocator
// Ring sub-allocator over a linear space, kept as an address-ordered region
// table with a block handle table, both in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (s_tuser selects allocate or free) and
//   one result per request leaves on the m_ channel. The managed size is
//   written on the cfg_ channel while the block is idle; a write rebuilds
//   the table as one free region.
//   One request is worked on at a time. Every step visits one region entry
//   through the single read port of the region memory, so an allocate grows
//   longer with each region merged at the head and at the cursor and with
//   each taken region stepped over after an exact fit. A free checks the handle
//   and region entries and adds the merge passes when the largest run is asked for.
//   After reset, and after a configuration write, the first region entry is
//   written before requests are taken.
//   The result waits in an output register; a stalled receiver holds it
//   there and the block may take and work on the next request, but will not
//   finish it until the register has been emptied.
// ----------------------------------------------------------------------------
module ring_region_allocator #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// Request channel
	input  logic          s_tvalid,
	output logic          s_tready,
	// alloc_size[31:0], handle_slot[37:32], handle_generation[69:38],
	// handle_offset[101:70], handle_size[133:102], report_max[134], zero[135]
	input  logic [135:0]  s_tdata,
	// req_type[0]
	input  logic [0:0]    s_tuser,
	// Result channel
	output logic          m_tvalid,
	input  logic          m_tready,
	// status[1:0], granted_offset[33:2], granted_size[65:34],
	// granted_slot[71:66], granted_generation[103:72], largest_free[135:104],
	// bytes_in_use[167:136], blocks_in_use[174:168], zero[175]
	output logic [175:0]  m_tdata,
	// Configuration channel: total_bytes
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data
);
	import rra_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam logic [LW-1:0] NONE = LW'(MAX_ENTRIES);
	localparam logic [LW-1:0] MAXC = LW'(MAX_ENTRIES);

	typedef struct packed {
		logic [31:0]   start;
		logic [31:0]   len;
		logic [LW-1:0] link;
		logic          taken;
	} region_t;

	typedef struct packed {
		logic [LW-1:0] rgn;
		logic [31:0]   gen;
	} blk_t;

	// Memories
	region_t rg_mem [MAX_ENTRIES];
	blk_t    blk_mem [MAX_ENTRIES];

	logic          rg_we, rg_re;
	logic [IW-1:0] rg_waddr, rg_raddr;
	region_t       rg_wdata, rg_rdata;
	logic          blk_we, blk_re;
	logic [IW-1:0] blk_waddr, blk_raddr;
	blk_t          blk_wdata, blk_rdata;

	// Spare stacks
	rra_stack_ctl_t rstk_ctl, bstk_ctl;
	logic [IW-1:0]  rstk_din, rstk_dout, bstk_din, bstk_dout;
	logic [LW-1:0]  rstk_cnt, bstk_cnt;

	// Control state
	rra_state_t    state_q, state_d;
	logic [31:0]   total_q;
	logic [LW-1:0] cursor_q;
	logic [LW-1:0] rg_used_q;
	logic [LW-1:0] blk_used_q;
	logic [31:0]   gen_next_q;
	logic [31:0]   bytes_q;
	logic [LW-1:0] blocks_q;
	logic          m_valid_q;

	// Request payload
	rra_req_t      req_type_q;
	logic [31:0]   req_size_q, req_gen_q, req_off_q, req_hsize_q;
	logic [5:0]    req_slot_q;
	logic          req_report_q;

	// Merge pass
	rra_phase_t    mph_q;
	logic [IW-1:0] mh_q;
	logic [31:0]   acc_len_q, acc_start_q;
	logic [LW-1:0] acc_link_q;
	logic          moved_q;
	logic [31:0]   hd_len_q, hd_start_q, cu_len_q, cu_start_q;
	logic [LW-1:0] hd_link_q, cu_link_q;
	logic [IW-1:0] cu_idx_q;

	// Selected region and cut
	logic [IW-1:0] sel_idx_q, n_q;
	logic [31:0]   sel_len_q, sel_start_q;
	logic [LW-1:0] sel_link_q, walk_q;
	logic          split_q, rpop_q, bpop_q;

	// Result
	rra_status_t   res_status_q;
	logic [31:0]   res_off_q, res_size_q, res_gen_q, res_largest_q;
	logic [5:0]    res_slot_q;
	logic [175:0]  m_data_q;

	// Input fields
	logic [31:0]   in_size, in_gen, in_off, in_hsize;
	logic [5:0]    in_slot;
	logic          in_report, in_slot_ok, s_acc;

	assign in_size   = s_tdata[31:0];
	assign in_slot   = s_tdata[37:32];
	assign in_gen    = s_tdata[69:38];
	assign in_off    = s_tdata[101:70];
	assign in_hsize  = s_tdata[133:102];
	assign in_report = s_tdata[134];
	assign in_slot_ok = 32'(in_slot) < 32'(blk_used_q);

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign s_acc     = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// Merge and decision signals
	logic          m_fin, fin_moved;
	logic [31:0]   fin_len, fin_start, mrg_len;
	logic [LW-1:0] fin_link, mrg_link, cur_after;
	logic          cur_fit, hd_fit, pick_cur, pick_hd, split_c, reg_ok, blk_ok;
	logic [31:0]   pk_len, pk_start, best, g_size;
	logic [LW-1:0] pk_link;
	logic [IW-1:0] pk_idx, n_idx, b_idx;
	logic          fb_bad, fr_ok, out_free;

	assign cur_fit  = (cu_len_q != '0) && (cu_len_q >= req_size_q);
	assign hd_fit   = (hd_len_q != '0) && (hd_len_q >= req_size_q);
	assign pick_cur = (req_size_q != '0) && cur_fit;
	assign pick_hd  = (req_size_q != '0) && !cur_fit && hd_fit;
	assign pk_len   = pick_cur ? cu_len_q : hd_len_q;
	assign pk_start = pick_cur ? cu_start_q : hd_start_q;
	assign pk_link  = pick_cur ? cu_link_q : hd_link_q;
	assign pk_idx   = pick_cur ? cu_idx_q : '0;
	assign split_c  = pk_len > req_size_q;
	assign reg_ok   = !split_c || (rstk_cnt != '0) || (rg_used_q < MAXC);
	assign blk_ok   = (bstk_cnt != '0) || (blk_used_q < MAXC);
	assign best     = (hd_len_q > cu_len_q) ? hd_len_q : cu_len_q;
	assign n_idx    = rpop_q ? rstk_dout : rg_used_q[IW-1:0];
	assign b_idx    = bpop_q ? bstk_dout : blk_used_q[IW-1:0];
	assign g_size   = split_q ? req_size_q : sel_len_q;
	assign fb_bad   = (blk_rdata.rgn >= NONE) || (blk_rdata.gen != req_gen_q);
	assign fr_ok    = rg_rdata.taken && (rg_rdata.start == req_off_q) &&
	                  (rg_rdata.len == req_hsize_q) && (req_hsize_q != '0);
	assign out_free = !m_valid_q || m_tready;
	assign cur_after = fin_moved ? LW'(mh_q) : cursor_q;

	// Region memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (rg_we) begin
			rg_mem[rg_waddr] <= rg_wdata;
		end
		if (rg_re) begin
			rg_rdata <= rg_mem[rg_raddr];
		end
	end

	// Block handle memory.
	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_waddr] <= blk_wdata;
		end
		if (blk_re) begin
			blk_rdata <= blk_mem[blk_raddr];
		end
	end

	rra_stack #(.DEPTH(MAX_ENTRIES), .DW(IW)) u_rgn_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rstk_ctl),
		.push_data (rstk_din),
		.pop_data  (rstk_dout),
		.count     (rstk_cnt)
	);

	rra_stack #(.DEPTH(MAX_ENTRIES), .DW(IW)) u_blk_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (bstk_ctl),
		.push_data (bstk_din),
		.pop_data  (bstk_dout),
		.count     (bstk_cnt)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory accesses and stack operations.
	always_comb begin
		state_d   = state_q;
		rg_we     = 1'b0;
		rg_waddr  = '0;
		rg_wdata  = '0;
		rg_re     = 1'b0;
		rg_raddr  = '0;
		blk_we    = 1'b0;
		blk_waddr = '0;
		blk_wdata = '0;
		blk_re    = 1'b0;
		blk_raddr = '0;
		rstk_ctl  = '0;
		rstk_din  = '0;
		bstk_ctl  = '0;
		bstk_din  = '0;
		m_fin     = 1'b0;
		fin_len   = acc_len_q;
		fin_link  = acc_link_q;
		fin_start = acc_start_q;
		fin_moved = moved_q;
		mrg_len   = acc_len_q + rg_rdata.len;
		mrg_link  = rg_rdata.link;
		unique case (state_q)
			ST_INIT: begin
				rg_we    = 1'b1;
				rg_wdata = '{start: '0, len: total_q, link: NONE, taken: 1'b0};
				state_d  = ST_IDLE;
			end
			ST_IDLE: begin
				if (cfg_valid) begin
					rstk_ctl.clear = 1'b1;
					bstk_ctl.clear = 1'b1;
					state_d = ST_INIT;
				end else if (s_tvalid) begin
					if (rra_req_t'(s_tuser[0]) == REQ_ALLOC) begin
						state_d = ST_MRD;
					end else if (in_slot_ok) begin
						state_d = ST_FBRD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MRD: begin
				rg_re    = 1'b1;
				rg_raddr = mh_q;
				state_d  = ST_MHEAD;
			end
			ST_MHEAD: begin
				if (rg_rdata.taken) begin
					m_fin     = 1'b1;
					fin_len   = '0;
					fin_link  = NONE;
					fin_start = '0;
					fin_moved = 1'b0;
				end else if (rg_rdata.link == NONE) begin
					m_fin     = 1'b1;
					fin_len   = rg_rdata.len;
					fin_link  = NONE;
					fin_start = rg_rdata.start;
					fin_moved = 1'b0;
				end else begin
					rg_re    = 1'b1;
					rg_raddr = rg_rdata.link[IW-1:0];
					state_d  = ST_MFOL;
				end
			end
			ST_MFOL: begin
				// The follower just read is acc_link_q.
				rg_waddr = mh_q;
				if (rg_rdata.taken) begin
					rg_we    = 1'b1;
					rg_wdata = '{start: acc_start_q, len: acc_len_q, link: acc_link_q,
					             taken: 1'b0};
					m_fin    = 1'b1;
				end else begin
					if (rstk_cnt != MAXC) begin
						rstk_ctl.push = 1'b1;
						rstk_din      = acc_link_q[IW-1:0];
					end
					fin_moved = moved_q || (acc_link_q == cursor_q);
					if (mrg_link == NONE) begin
						rg_we    = 1'b1;
						rg_wdata = '{start: acc_start_q, len: mrg_len, link: NONE,
						             taken: 1'b0};
						m_fin    = 1'b1;
						fin_len  = mrg_len;
						fin_link = NONE;
					end else begin
						rg_re    = 1'b1;
						rg_raddr = mrg_link[IW-1:0];
					end
				end
			end
			ST_DECIDE: begin
				if (req_type_q == REQ_FREE || !(pick_cur || pick_hd) ||
				    !reg_ok || !blk_ok) begin
					state_d = ST_DONE;
				end else begin
					rstk_ctl.pop = split_c && (rstk_cnt != '0);
					bstk_ctl.pop = bstk_cnt != '0;
					state_d = ST_ACUT;
				end
			end
			ST_ACUT: begin
				blk_we    = 1'b1;
				blk_waddr = b_idx;
				blk_wdata = '{rgn: LW'(sel_idx_q), gen: gen_next_q};
				rg_we     = 1'b1;
				rg_waddr  = sel_idx_q;
				if (split_q) begin
					rg_wdata = '{start: sel_start_q, len: req_size_q, link: LW'(n_idx),
					             taken: 1'b1};
					state_d  = ST_ANEW;
				end else begin
					rg_wdata = '{start: sel_start_q, len: sel_len_q, link: sel_link_q,
					             taken: 1'b1};
					if (sel_link_q == NONE) begin
						state_d = ST_DONE;
					end else begin
						rg_re    = 1'b1;
						rg_raddr = sel_link_q[IW-1:0];
						state_d  = ST_AWALK;
					end
				end
			end
			ST_ANEW: begin
				rg_we    = 1'b1;
				rg_waddr = n_q;
				rg_wdata = '{start: sel_start_q + req_size_q, len: sel_len_q - req_size_q,
				             link: sel_link_q, taken: 1'b0};
				state_d  = ST_DONE;
			end
			ST_AWALK: begin
				if (!rg_rdata.taken || rg_rdata.link == NONE) begin
					state_d = ST_DONE;
				end else begin
					rg_re    = 1'b1;
					rg_raddr = rg_rdata.link[IW-1:0];
				end
			end
			ST_FBRD: begin
				blk_re    = 1'b1;
				blk_raddr = IW'(req_slot_q);
				state_d   = ST_FBCHK;
			end
			ST_FBCHK: begin
				if (fb_bad) begin
					state_d = ST_DONE;
				end else begin
					rg_re    = 1'b1;
					rg_raddr = blk_rdata.rgn[IW-1:0];
					state_d  = ST_FRCHK;
				end
			end
			ST_FRCHK: begin
				if (!fr_ok) begin
					state_d = ST_DONE;
				end else begin
					rg_we     = 1'b1;
					rg_waddr  = sel_idx_q;
					rg_wdata  = rg_rdata;
					rg_wdata.taken = 1'b0;
					blk_we    = 1'b1;
					blk_waddr = IW'(req_slot_q);
					blk_wdata = '{rgn: NONE, gen: '0};
					if (bstk_cnt != MAXC) begin
						bstk_ctl.push = 1'b1;
						bstk_din      = IW'(req_slot_q);
					end
					state_d = req_report_q ? ST_MRD : ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
		// End of a merge pass: go on to the cursor run or to the decision.
		if (m_fin) begin
			if (mph_q == PH_HEAD && cur_after != '0 && cur_after < NONE) begin
				state_d = ST_MRD;
			end else begin
				state_d = ST_DECIDE;
			end
		end
	end

	// Counters, cursor and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= 32'd65536;
			cursor_q   <= '0;
			rg_used_q  <= LW'(1);
			blk_used_q <= '0;
			gen_next_q <= '0;
			bytes_q    <= '0;
			blocks_q   <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			// A finished result loads the output register as it empties.
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						total_q    <= cfg_data;
						cursor_q   <= '0;
						rg_used_q  <= LW'(1);
						blk_used_q <= '0;
						bytes_q    <= '0;
						blocks_q   <= '0;
					end
				end
				ST_MHEAD, ST_MFOL: begin
					if (m_fin && fin_moved) begin
						cursor_q <= LW'(mh_q);
					end
				end
				ST_ACUT: begin
					gen_next_q <= gen_next_q + 32'd1;
					blocks_q   <= blocks_q + LW'(1);
					bytes_q    <= bytes_q + g_size;
					if (!bpop_q) begin
						blk_used_q <= blk_used_q + LW'(1);
					end
					if (split_q) begin
						cursor_q <= LW'(n_idx);
						if (!rpop_q) begin
							rg_used_q <= rg_used_q + LW'(1);
						end
					end else if (sel_link_q == NONE) begin
						cursor_q <= NONE;
					end
				end
				ST_AWALK: begin
					if (!rg_rdata.taken) begin
						cursor_q <= walk_q;
					end else if (rg_rdata.link == NONE) begin
						cursor_q <= NONE;
					end
				end
				ST_FRCHK: begin
					if (fr_ok) begin
						blocks_q <= blocks_q - LW'(1);
						bytes_q  <= bytes_q - rg_rdata.len;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request, merge and result payload registers.
	always_ff @(posedge clk) begin
		if (m_fin) begin
			if (mph_q == PH_HEAD) begin
				hd_len_q   <= fin_len;
				hd_link_q  <= fin_link;
				hd_start_q <= fin_start;
				cu_len_q   <= '0;
				mph_q      <= PH_CURSOR;
				mh_q       <= cur_after[IW-1:0];
				moved_q    <= 1'b0;
			end else begin
				cu_len_q   <= fin_len;
				cu_link_q  <= fin_link;
				cu_start_q <= fin_start;
				cu_idx_q   <= mh_q;
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					req_type_q    <= rra_req_t'(s_tuser[0]);
					req_size_q    <= in_size;
					req_slot_q    <= in_slot;
					req_gen_q     <= in_gen;
					req_off_q     <= in_off;
					req_hsize_q   <= in_hsize;
					req_report_q  <= in_report;
					mph_q         <= PH_HEAD;
					mh_q          <= '0;
					moved_q       <= 1'b0;
					res_status_q  <= STAT_OK;
					res_off_q     <= '0;
					res_size_q    <= '0;
					res_slot_q    <= '0;
					res_gen_q     <= '0;
					res_largest_q <= '0;
					if (rra_req_t'(s_tuser[0]) == REQ_FREE && !in_slot_ok) begin
						res_status_q <= STAT_BAD_HANDLE;
					end
				end
			end
			ST_MHEAD: begin
				if (!m_fin) begin
					acc_len_q   <= rg_rdata.len;
					acc_link_q  <= rg_rdata.link;
					acc_start_q <= rg_rdata.start;
				end
			end
			ST_MFOL: begin
				if (!rg_rdata.taken && !m_fin) begin
					acc_len_q  <= mrg_len;
					acc_link_q <= mrg_link;
					moved_q    <= fin_moved;
				end
			end
			ST_DECIDE: begin
				if (req_type_q == REQ_FREE) begin
					res_largest_q <= best;
				end else if (!(pick_cur || pick_hd)) begin
					res_status_q  <= STAT_NO_SPACE;
					res_largest_q <= best;
				end else if (!reg_ok || !blk_ok) begin
					res_status_q  <= STAT_TABLE_FULL;
					res_largest_q <= best;
				end else begin
					sel_idx_q   <= pk_idx;
					sel_len_q   <= pk_len;
					sel_link_q  <= pk_link;
					sel_start_q <= pk_start;
					split_q     <= split_c;
					rpop_q      <= split_c && (rstk_cnt != '0);
					bpop_q      <= bstk_cnt != '0;
				end
			end
			ST_ACUT: begin
				n_q        <= n_idx;
				walk_q     <= sel_link_q;
				res_off_q  <= sel_start_q;
				res_size_q <= g_size;
				res_slot_q <= 6'(b_idx);
				res_gen_q  <= gen_next_q;
			end
			ST_AWALK: begin
				walk_q <= rg_rdata.link;
			end
			ST_FBCHK: begin
				sel_idx_q <= blk_rdata.rgn[IW-1:0];
				if (fb_bad) begin
					res_status_q <= STAT_BAD_HANDLE;
				end
			end
			ST_FRCHK: begin
				if (!fr_ok) begin
					res_status_q <= STAT_BAD_HANDLE;
				end else if (req_report_q) begin
					mph_q   <= PH_HEAD;
					mh_q    <= '0;
					moved_q <= 1'b0;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {1'b0, 7'(blocks_q), bytes_q, res_largest_q, res_gen_q,
					             res_slot_q, res_size_q, res_off_q, res_status_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Checks on the sequencer.
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rg_we && rg_re) |-> (rg_waddr != rg_raddr))
		else $error("region entry read while it is written");
	a_cfg_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (state_q == ST_INIT))
		else $error("configuration write did not rebuild the table");
	a_blocks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(blocks_q <= MAXC) && (blocks_q <= blk_used_q))
		else $error("block count exceeds handed-out slots");
	a_regions_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rg_used_q <= MAXC) && (rg_used_q != '0))
		else $error("region table fill count out of range");

endmodule

// ----- src/rra_stack.sv -----
// ----------------------------------------------------------------------------
// Spare index stack
// A LIFO of free table indexes held in a memory with a registered pop read.
// ----------------------------------------------------------------------------
module rra_stack #(
	parameter int DEPTH = 64,
	parameter int DW    = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rra_pkg::rra_stack_ctl_t      ctl,
	input  logic [DW-1:0]                push_data,
	output logic [DW-1:0]                pop_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	import rra_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem [DEPTH];
	logic [CW-1:0] cnt_m1;

	assign cnt_m1 = count - CW'(1);

	// Storage: push writes at the top, pop reads the entry below it.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[count[AW-1:0]] <= push_data;
		end
		if (ctl.pop) begin
			pop_data <= mem[cnt_m1[AW-1:0]];
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count <= '0;
		end else if (ctl.clear) begin
			count <= '0;
		end else if (ctl.push) begin
			count <= count + CW'(1);
		end else if (ctl.pop) begin
			count <= cnt_m1;
		end
	end

	// Checks on the use of the stack.
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("stack pushed and popped in one cycle");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count != '0)
		else $error("stack popped while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> count != CW'(DEPTH))
		else $error("stack pushed while full");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring region allocator testbench
// Drives allocate and free requests with random gaps on both channels and
// compares every result against a behavioural predictor of the region and
// block tables, over several managed sizes including the extremes.
// ----------------------------------------------------------------------------
module testbench;
	import rra_pkg::*;

	localparam int ENTRIES = 64;
	localparam int NO_LINK = ENTRIES;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1480;

	typedef struct {
		rra_req_t    kind;
		logic [31:0] size;
		logic [5:0]  slot;
		logic [31:0] gen;
		logic [31:0] offset;
		logic [31:0] hsize;
		logic        report;
	} request_t;

	typedef struct {
		rra_status_t status;
		logic [31:0] offset;
		logic [31:0] size;
		logic [5:0]  slot;
		logic [31:0] gen;
		logic [31:0] largest;
		logic [31:0] bytes;
		logic [6:0]  blocks;
	} result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [135:0]  s_tdata = '0;
	logic [0:0]    s_tuser = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [175:0]  m_tdata;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [31:0]   cfg_data = '0;

	// Predictor state: region table, block table and counters.
	logic [31:0] total;
	logic [31:0] rg_start [ENTRIES];
	logic [31:0] rg_len [ENTRIES];
	int          rg_link [ENTRIES];
	bit          rg_taken [ENTRIES];
	int          rg_spare [ENTRIES];
	int          rg_spare_n, rg_used, cursor;
	int          blk_ref [ENTRIES];
	logic [31:0] blk_gen [ENTRIES];
	int          blk_spare [ENTRIES];
	int          blk_spare_n, blk_used;
	logic [31:0] gen_next, bytes_used;
	logic [6:0]  blocks_used;

	result_t  expected_results [$];
	request_t live_handles [$];
	int       errors = 0;
	int       checked = 0;
	longint   cycles = 0;
	bit       no_idle = 0;
	int       sink_hold = 0;
	int       n_ok = 0, n_nospace = 0, n_bad = 0, n_full = 0;

	ring_region_allocator #(.MAX_ENTRIES(ENTRIES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Clock generation.
	always #2 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Rebuild the tables as one free region of the managed size.
	function automatic void tables_reinit();
		for (int i = 0; i < ENTRIES; i++) begin
			rg_start[i] = 0; rg_len[i] = 0; rg_link[i] = NO_LINK; rg_taken[i] = 0;
			blk_ref[i] = 0; blk_gen[i] = 0;
		end
		rg_len[0] = total;
		rg_spare_n = 0; rg_used = 1; cursor = 0;
		blk_spare_n = 0; blk_used = 0;
		bytes_used = 0; blocks_used = 0;
	endfunction

	// Absorb the free followers of region h; returns the run length.
	function automatic logic [31:0] merge_into(int h);
		bit moved;
		int f, top;
		if (h >= NO_LINK || rg_taken[h]) return 0;
		moved = 0;
		f = rg_link[h];
		for (int n = 0; n < ENTRIES && f < NO_LINK; n++) begin
			if (rg_taken[f]) break;
			if (f == cursor) moved = 1;
			rg_len[h] += rg_len[f];
			rg_link[h] = rg_link[f];
			if (rg_spare_n < ENTRIES) begin
				rg_spare[rg_spare_n] = f;
				rg_spare_n++;
			end
			f = rg_link[f];
			top = rg_spare[rg_spare_n - 1];
			rg_len[top] = 0; rg_start[top] = 0; rg_link[top] = NO_LINK;
		end
		if (moved) cursor = h;
		return rg_len[h];
	endfunction

	// Merge at the head and at the cursor; returns the larger run.
	function automatic logic [31:0] merge_head_cursor(output logic [31:0] cur_run);
		logic [31:0] head_run;
		head_run = merge_into(0);
		cur_run = 0;
		if (cursor > 0 && cursor < NO_LINK) cur_run = merge_into(cursor);
		return head_run > cur_run ? head_run : cur_run;
	endfunction

	// Work out the result of one request and advance the tables.
	function automatic result_t allocator_predict(request_t rq);
		result_t res;
		logic [31:0] head_run, cur_run, best;
		int r, n, b, f;
		bit split, ok;
		res = '{STAT_OK, 0, 0, 0, 0, 0, 0, 0};
		if (rq.kind == REQ_ALLOC) begin
			head_run = merge_into(0);
			cur_run = 0;
			if (cursor > 0 && cursor < NO_LINK) cur_run = merge_into(cursor);
			best = head_run > cur_run ? head_run : cur_run;
			r = NO_LINK;
			if (rq.size != 0) begin
				if (cur_run != 0 && cur_run >= rq.size) r = cursor;
				else if (head_run != 0 && head_run >= rq.size) r = 0;
			end
			if (r == NO_LINK) begin
				res.status = STAT_NO_SPACE;
				res.largest = best;
			end else begin
				split = rg_len[r] > rq.size;
				if ((split && rg_spare_n == 0 && rg_used >= ENTRIES) ||
				    (blk_spare_n == 0 && blk_used >= ENTRIES)) begin
					res.status = STAT_TABLE_FULL;
					res.largest = best;
				end else begin
					rg_taken[r] = 1;
					if (split) begin
						if (rg_spare_n > 0) begin
							rg_spare_n--;
							n = rg_spare[rg_spare_n];
						end else begin
							n = rg_used;
							rg_used++;
						end
						n = n % ENTRIES;
						rg_start[n] = rg_start[r] + rq.size;
						rg_len[n] = rg_len[r] - rq.size;
						rg_link[n] = rg_link[r];
						rg_taken[n] = 0;
						rg_link[r] = n;
						rg_len[r] = rq.size;
						cursor = n;
					end else begin
						// Exact fit: step over taken followers.
						f = rg_link[r];
						for (int k = 0; k < ENTRIES && f < NO_LINK; k++) begin
							if (!rg_taken[f]) break;
							f = rg_link[f];
						end
						cursor = f < NO_LINK ? f : NO_LINK;
					end
					if (blk_spare_n > 0) begin
						blk_spare_n--;
						b = blk_spare[blk_spare_n];
					end else begin
						b = blk_used;
						blk_used++;
					end
					b = b % ENTRIES;
					blk_ref[b] = r;
					blk_gen[b] = gen_next;
					res.gen = gen_next;
					gen_next++;
					res.offset = rg_start[r];
					res.size = rg_len[r];
					res.slot = 6'(b);
					blocks_used++;
					bytes_used += res.size;
				end
			end
		end else begin
			ok = rq.slot < blk_used;
			r = ok ? blk_ref[rq.slot] : NO_LINK;
			ok = ok && r < NO_LINK && blk_gen[rq.slot] == rq.gen;
			ok = ok && rg_taken[r] && rg_start[r] == rq.offset &&
			     rg_len[r] == rq.hsize && rq.hsize != 0;
			if (!ok) begin
				res.status = STAT_BAD_HANDLE;
			end else begin
				rg_taken[r] = 0;
				blocks_used--;
				bytes_used -= rg_len[r];
				blk_ref[rq.slot] = NO_LINK;
				blk_gen[rq.slot] = 0;
				if (blk_spare_n < ENTRIES) begin
					blk_spare[blk_spare_n] = rq.slot;
					blk_spare_n++;
				end
				if (rq.report) res.largest = merge_head_cursor(cur_run);
			end
		end
		res.bytes = bytes_used;
		res.blocks = blocks_used;
		return res;
	endfunction

	// Send one request and record the result it must produce.
	task automatic send_request(input request_t rq);
		int g;
		result_t res;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.kind;
		s_tdata <= {1'b0, rq.report, rq.hsize, rq.offset, rq.gen, rq.slot, rq.size};
		do @(posedge clk); while (!s_tready);
		res = allocator_predict(rq);
		expected_results.push_back(res);
		case (res.status)
			STAT_OK:         n_ok++;
			STAT_NO_SPACE:   n_nospace++;
			STAT_BAD_HANDLE: n_bad++;
			default:         n_full++;
		endcase
		if (rq.kind == REQ_ALLOC && res.status == STAT_OK) begin
			live_handles.push_back('{REQ_FREE, 0, res.slot, res.gen, res.offset, res.size, 0});
		end else if (rq.kind == REQ_FREE && res.status == STAT_OK) begin
			foreach (live_handles[i]) begin
				if (live_handles[i].slot == rq.slot) begin
					live_handles.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic do_alloc(input logic [31:0] size);
		send_request('{REQ_ALLOC, size, 6'($urandom), $urandom, $urandom, $urandom,
		               1'($urandom)});
	endtask

	// Free a live handle, optionally corrupting one field of it.
	task automatic do_free(input int idx, input bit report, input int corrupt);
		request_t rq;
		rq = live_handles[idx];
		rq.report = report;
		rq.size = $urandom;
		case (corrupt)
			1: rq.gen ^= 32'd1 << $urandom_range(0, 31);
			2: rq.offset ^= 32'd1 << $urandom_range(0, 31);
			3: rq.hsize ^= 32'd1 << $urandom_range(0, 31);
			4: rq.slot ^= 6'd1 << $urandom_range(0, 5);
			default: ;
		endcase
		send_request(rq);
	endtask

	// Let the block go idle: all results in, then a quiet spell.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_total(input logic [31:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		total = value;
		tables_reinit();
		live_handles.delete();
	endtask

	// Zero size, oversize, exact fit, wrap to the head and bad handles.
	task automatic test_directed();
		request_t rq;
		do_alloc(0);
		do_alloc(32'hFFFF_FFFF);
		do_alloc(1);
		do_alloc(100);
		do_free(0, 1'b0, 0);
		do_free(0, 1'b1, 0);
		rq = '{REQ_FREE, 0, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
		send_request(rq);
		do_alloc(65536 - 101);
		do_free(0, 1'b1, 1);
		do_free(0, 1'b1, 2);
		do_free(0, 1'b0, 3);
		do_free(0, 1'b1, 4);
		write_total(300);
		do_alloc(100);
		do_alloc(100);
		do_alloc(100);
		do_alloc(1);
		do_free(1, 1'b1, 0);
		do_alloc(100);
		do_alloc(50);
		write_total(0);
		do_alloc(1);
		do_alloc(0);
		write_total(32'hFFFF_FFFF);
		do_alloc(32'hFFFF_FFFF);
		do_alloc(1);
	endtask

	// Allocate until the region table overflows, free eight blocks and allocate again.
	task automatic test_table_full();
		write_total(65536);
		for (int i = 0; i < ENTRIES + 2; i++) do_alloc($urandom_range(1, 64));
		for (int i = 0; i < 8; i++)
			do_free($urandom_range(0, live_handles.size() - 1), $urandom_range(0, 1), 0);
		for (int i = 0; i < 12; i++) do_alloc($urandom_range(1, 300));
	endtask

	// Mixed traffic over one managed size.
	task automatic test_random_mix(input logic [31:0] size_total, input int items);
		int r;
		longint span;
		write_total(size_total);
		no_idle = ($urandom_range(0, 3) == 0);
		span = size_total / 24 + 1;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50 || live_handles.size() == 0) begin
				if (r < 2) do_alloc(0);
				else if (r < 4) do_alloc($urandom);
				else do_alloc($urandom_range(1, span));
			end else if (r < 88) begin
				do_free($urandom_range(0, live_handles.size() - 1), $urandom_range(0, 1), 0);
			end else begin
				do_free($urandom_range(0, live_handles.size() - 1), $urandom_range(0, 1),
				        $urandom_range(1, 4));
			end
		end
		no_idle = 0;
	endtask

	// Receiver readiness with random stalls.
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 4) == 0) sink_hold <= pick_gap();
		end
	end

	function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
		end
	endfunction

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %0h", $realtime, m_tdata);
			end else begin
				exp_r = expected_results.pop_front();
				checked++;
				field_check("status", 32'(exp_r.status), 32'(m_tdata[1:0]));
				field_check("granted_offset", exp_r.offset, m_tdata[33:2]);
				field_check("granted_size", exp_r.size, m_tdata[65:34]);
				field_check("granted_slot", 32'(exp_r.slot), 32'(m_tdata[71:66]));
				field_check("granted_generation", exp_r.gen, m_tdata[103:72]);
				field_check("largest_free", exp_r.largest, m_tdata[135:104]);
				field_check("bytes_in_use", exp_r.bytes, m_tdata[167:136]);
				field_check("blocks_in_use", 32'(exp_r.blocks), 32'(m_tdata[174:168]));
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("ring_region_allocator: mismatch");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		total = 65536;
		gen_next = 0;
		tables_reinit();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random_mix(65536, RANDOM_ITEMS / 4);
		test_random_mix(1, 60);
		test_random_mix($urandom_range(200, 5000), RANDOM_ITEMS / 4);
		test_random_mix(32'hFFFF_FFFF, RANDOM_ITEMS / 4);
		test_random_mix($urandom, RANDOM_ITEMS / 4);
		wait_idle();
		if (expected_results.size() != 0) errors++;
		$display("Checked %0d results: %0d granted or freed, %0d no space, %0d bad handle,",
		         checked, n_ok, n_nospace, n_bad);
		$display("%0d table full, over managed sizes from 0 to the full 32-bit range.", n_full);
		if (errors == 0) begin
			$display("ring_region_allocator: match");
		end else begin
			$display("ring_region_allocator: mismatch");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/rra_pkg.sv
src/rra_stack.sv
src/ring_region_allocator.sv
bench/testbench.sv
